[design/tepe_pkg.sv]
package tepe_pkg;

    // Event fields and limits
    localparam int NUM_VALUE_FIELDS = 4;
    localparam int MAX_VALUES       = 4;
    localparam int EFF_MAX_VALUES   = (MAX_VALUES < NUM_VALUE_FIELDS) ? MAX_VALUES
                                                                      : NUM_VALUE_FIELDS;
    localparam int SHORT_ID_LIMIT   = 24;
    localparam int LONG_ID_MAX      = 127;

    // Varint coding
    localparam logic [7:0] VARINT_MASK  = 8'h7F;
    localparam logic [7:0] CONT_BIT     = 8'h80;
    localparam int         VARINT_SHIFT = 7;

    // Widths of the length bookkeeping
    localparam int VLEN_W  = 3;    // bytes of one 32-bit varint, 1..5
    localparam int PLEN_W  = 6;    // payload bytes
    localparam int OLEN_W  = 4;    // overflow packet bytes
    localparam int ELEN_W  = 7;    // event packet bytes
    localparam int IDX_W   = 3;    // length slots and value index

    // Length slots walked by the shared length unit
    localparam logic [IDX_W-1:0] SLOT_DELTA   = 3'd4;
    localparam logic [IDX_W-1:0] SLOT_DROPPED = 3'd5;
    localparam logic [IDX_W-1:0] SLOT_DROPINC = 3'd6;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_TRACING_ON   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLASS_MASK   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OVERFLOW_ID  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEN,
        S_CHECK,
        S_DECIDE,
        S_OVF_HDR,
        S_OVF_CNT,
        S_OVF_DLT,
        S_EVT_HDR,
        S_EVT_LOAD,
        S_EVT_VAL,
        S_EVT_DLT
    } state_t;

endpackage

[design/trace_event_packet_encoder_top.sv]
// Flow: an enabled item is accepted, S_LEN sizes its varints, S_CHECK and S_DECIDE
//   choose the packets, then the first byte is offered; filtered items stay idle.
// Throughput: one byte per cycle while out_stall is low, plus an S_EVT_LOAD step
//   per payload value; input is ready again the cycle after the last byte.
// The shared varint length unit and the single 7-bit serializer set this pace.
// Reset (rst_n low, asynchronous): idle, tracing off, overflow id 1, counters cleared.
module trace_event_packet_encoder_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  event_id,
    input  logic [2:0]  event_class,
    input  logic [2:0]  value_count,
    input  logic [31:0] value_a,
    input  logic [31:0] value_b,
    input  logic [31:0] value_c,
    input  logic [31:0] value_d,
    input  logic [31:0] timestamp,
    input  logic [15:0] fifo_space,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        is_overflow_packet,
    output logic        last_byte,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tepe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                         cfg_data
);

    // Control state
    tepe_pkg::state_t state_reg, state_next;
    logic        tracing_on_reg;
    logic [7:0]  class_mask_reg;
    logic [4:0]  ovf_id_reg;
    logic        pending_reg, pending_next;
    logic [31:0] dropped_reg, dropped_next;
    logic [31:0] last_ts_reg, last_ts_next;
    logic [tepe_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic        do_evt_reg, do_evt_next;
    logic        do_ovf2_reg, do_ovf2_next;
    logic        cur_ovf2_reg, cur_ovf2_next;

    // Item payload and working registers
    logic [7:0]  id_reg, id_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] val_reg [tepe_pkg::NUM_VALUE_FIELDS];
    logic [31:0] ts_reg, ts_next;
    logic [15:0] space_reg, space_next;
    logic [31:0] delta_reg, delta_next;
    logic [31:0] dcnt_reg, dcnt_next;
    logic [31:0] dinc_reg, dinc_next;
    logic        pend_snap_reg, pend_snap_next;
    logic [tepe_pkg::PLEN_W-1:0] plen_reg, plen_next;
    logic [tepe_pkg::VLEN_W-1:0] dlen_reg, dlen_next;
    logic [tepe_pkg::VLEN_W-1:0] clen_reg, clen_next;
    logic [tepe_pkg::VLEN_W-1:0] ilen_reg, ilen_next;
    logic        ok1_reg, ok1_next;
    logic [31:0] ser_reg, ser_next;

    // Combinational helpers
    logic        accept;
    logic        step;
    logic        enabled;
    logic [2:0]  cnt_clamped;
    logic [31:0] val_rd;
    logic [31:0] vlen_op;
    logic [tepe_pkg::VLEN_W-1:0] vlen;
    logic        ser_done;
    logic [7:0]  var_byte;
    logic [7:0]  hdr_byte;
    logic [1:0]  hdr_len;
    logic        hdr_last;
    logic        id_short;
    logic        id_two;
    logic [tepe_pkg::ELEN_W-1:0] evt_len;
    logic [tepe_pkg::OLEN_W-1:0] olen1;
    logic [tepe_pkg::OLEN_W-1:0] olen2;
    logic        evt_ok;
    logic        ovf2_ok;
    logic        skip_evt;
    logic        more_vals;
    logic [31:0] ovf_cnt_op;
    logic [31:0] ovf_dlt_op;

    // Handshakes
    assign in_stall  = (state_reg != tepe_pkg::S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign step      = out_valid && !out_stall;
    assign cfg_ready = 1'b1;

    // Filter and clamp at acceptance
    assign enabled     = tracing_on_reg && !class_mask_reg[event_class];
    assign cnt_clamped = (value_count > 3'(tepe_pkg::EFF_MAX_VALUES))
                         ? 3'(tepe_pkg::EFF_MAX_VALUES) : value_count;

    // Shared length unit operand: values, delta, dropped, dropped plus one
    assign val_rd = val_reg[idx_reg[1:0]];

    always_comb
    begin
        unique case (idx_reg)
            tepe_pkg::SLOT_DELTA:   vlen_op = delta_reg;
            tepe_pkg::SLOT_DROPPED: vlen_op = dcnt_reg;
            tepe_pkg::SLOT_DROPINC: vlen_op = dinc_reg;
            default:                vlen_op = val_rd;
        endcase
    end

    tepe_vlen u_vlen
    (
        .value  (vlen_op),
        .nbytes (vlen)
    );

    // Serializer byte
    assign ser_done = (ser_reg[31:tepe_pkg::VARINT_SHIFT] == '0);
    assign var_byte = (ser_reg[7:0] & tepe_pkg::VARINT_MASK)
                      | (ser_done ? 8'h00 : tepe_pkg::CONT_BIT);

    // Event header
    assign id_short = (id_reg < 8'(tepe_pkg::SHORT_ID_LIMIT));
    assign id_two   = (id_reg > 8'(tepe_pkg::LONG_ID_MAX));
    assign hdr_len  = id_short ? 2'd1 : (id_two ? 2'd3 : 2'd2);
    assign hdr_last = (idx_reg == {1'b0, hdr_len - 2'd1});

    always_comb
    begin
        if (id_short)
        begin
            hdr_byte = id_reg;
        end
        else if (id_two)
        begin
            unique case (idx_reg[1:0])
                2'd0:    hdr_byte = id_reg | tepe_pkg::CONT_BIT;
                2'd1:    hdr_byte = 8'(id_reg >> tepe_pkg::VARINT_SHIFT);
                default: hdr_byte = {2'b00, plen_reg};
            endcase
        end
        else
        begin
            hdr_byte = (idx_reg[1:0] == 2'd0) ? id_reg : {2'b00, plen_reg};
        end
    end

    // Packet lengths and fit decisions
    assign evt_len  = 7'(hdr_len) + 7'(plen_reg) + 7'(dlen_reg);
    assign olen1    = 4'd1 + 4'(clen_reg) + 4'(dlen_reg);
    assign olen2    = pend_snap_reg ? 4'd3 : (4'd1 + 4'(ilen_reg) + 4'(dlen_reg));
    assign evt_ok   = (space_reg > 16'(evt_len));
    assign ovf2_ok  = (space_reg > 16'(olen2));
    assign skip_evt = pend_snap_reg && !ok1_reg;
    assign more_vals = ({1'b0, idx_reg[1:0]} + 3'd1) < cnt_reg;

    // Overflow packet operands: a retry after a flush sends count one, delta zero
    assign ovf_cnt_op = cur_ovf2_reg ? (pend_snap_reg ? 32'd1 : dinc_reg) : dcnt_reg;
    assign ovf_dlt_op = (cur_ovf2_reg && pend_snap_reg) ? 32'd0 : delta_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tepe_pkg::S_IDLE:
            begin
                if (accept && enabled)
                begin
                    state_next = tepe_pkg::S_LEN;
                end
            end
            tepe_pkg::S_LEN:
            begin
                if (idx_reg == tepe_pkg::SLOT_DROPINC)
                begin
                    state_next = tepe_pkg::S_CHECK;
                end
            end
            tepe_pkg::S_CHECK:
            begin
                state_next = tepe_pkg::S_DECIDE;
            end
            tepe_pkg::S_DECIDE:
            begin
                priority if (skip_evt)
                begin
                    state_next = tepe_pkg::S_IDLE;
                end
                else if (pend_snap_reg)
                begin
                    state_next = tepe_pkg::S_OVF_HDR;
                end
                else if (evt_ok)
                begin
                    state_next = tepe_pkg::S_EVT_HDR;
                end
                else if (ovf2_ok)
                begin
                    state_next = tepe_pkg::S_OVF_HDR;
                end
                else
                begin
                    state_next = tepe_pkg::S_IDLE;
                end
            end
            tepe_pkg::S_OVF_HDR:
            begin
                if (step)
                begin
                    state_next = tepe_pkg::S_OVF_CNT;
                end
            end
            tepe_pkg::S_OVF_CNT:
            begin
                if (step && ser_done)
                begin
                    state_next = tepe_pkg::S_OVF_DLT;
                end
            end
            tepe_pkg::S_OVF_DLT:
            begin
                if (step && ser_done)
                begin
                    priority if (cur_ovf2_reg)
                    begin
                        state_next = tepe_pkg::S_IDLE;
                    end
                    else if (do_evt_reg)
                    begin
                        state_next = tepe_pkg::S_EVT_HDR;
                    end
                    else if (do_ovf2_reg)
                    begin
                        state_next = tepe_pkg::S_OVF_HDR;
                    end
                    else
                    begin
                        state_next = tepe_pkg::S_IDLE;
                    end
                end
            end
            tepe_pkg::S_EVT_HDR:
            begin
                if (step && hdr_last)
                begin
                    state_next = (cnt_reg != '0) ? tepe_pkg::S_EVT_LOAD : tepe_pkg::S_EVT_DLT;
                end
            end
            tepe_pkg::S_EVT_LOAD:
            begin
                state_next = tepe_pkg::S_EVT_VAL;
            end
            tepe_pkg::S_EVT_VAL:
            begin
                if (step && ser_done)
                begin
                    state_next = more_vals ? tepe_pkg::S_EVT_LOAD : tepe_pkg::S_EVT_DLT;
                end
            end
            tepe_pkg::S_EVT_DLT:
            begin
                if (step && ser_done)
                begin
                    state_next = tepe_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tepe_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        out_valid          = 1'b0;
        out_byte           = var_byte;
        is_overflow_packet = 1'b0;
        last_byte          = 1'b0;
        unique case (state_reg)
            tepe_pkg::S_OVF_HDR:
            begin
                out_valid          = 1'b1;
                out_byte           = {3'b000, ovf_id_reg};
                is_overflow_packet = 1'b1;
            end
            tepe_pkg::S_OVF_CNT:
            begin
                out_valid          = 1'b1;
                is_overflow_packet = 1'b1;
            end
            tepe_pkg::S_OVF_DLT:
            begin
                out_valid          = 1'b1;
                is_overflow_packet = 1'b1;
                last_byte          = ser_done
                                     && (cur_ovf2_reg || (!do_evt_reg && !do_ovf2_reg));
            end
            tepe_pkg::S_EVT_HDR:
            begin
                out_valid = 1'b1;
                out_byte  = hdr_byte;
            end
            tepe_pkg::S_EVT_VAL:
            begin
                out_valid = 1'b1;
            end
            tepe_pkg::S_EVT_DLT:
            begin
                out_valid = 1'b1;
                last_byte = ser_done;
            end
            default:
            begin
                out_valid = 1'b0;
            end
        endcase
    end

    // Datapath and bookkeeping
    always_comb
    begin
        pending_next   = pending_reg;
        dropped_next   = dropped_reg;
        last_ts_next   = last_ts_reg;
        idx_next       = idx_reg;
        do_evt_next    = do_evt_reg;
        do_ovf2_next   = do_ovf2_reg;
        cur_ovf2_next  = cur_ovf2_reg;
        id_next        = id_reg;
        cnt_next       = cnt_reg;
        ts_next        = ts_reg;
        space_next     = space_reg;
        delta_next     = delta_reg;
        dcnt_next      = dcnt_reg;
        dinc_next      = dinc_reg;
        pend_snap_next = pend_snap_reg;
        plen_next      = plen_reg;
        dlen_next      = dlen_reg;
        clen_next      = clen_reg;
        ilen_next      = ilen_reg;
        ok1_next       = ok1_reg;
        ser_next       = ser_reg;

        unique case (state_reg)
            tepe_pkg::S_IDLE:
            begin
                // Capture the item and the state it sees
                if (accept)
                begin
                    id_next        = event_id;
                    cnt_next       = cnt_clamped;
                    ts_next        = timestamp;
                    space_next     = fifo_space;
                    delta_next     = timestamp - last_ts_reg;
                    dcnt_next      = dropped_reg;
                    dinc_next      = dropped_reg + 32'd1;
                    pend_snap_next = pending_reg;
                    plen_next      = '0;
                    idx_next       = '0;
                end
            end
            tepe_pkg::S_LEN:
            begin
                // Accumulate varint lengths, one operand per cycle
                if (idx_reg < cnt_reg)
                begin
                    plen_next = plen_reg + tepe_pkg::PLEN_W'(vlen);
                end
                if (idx_reg == tepe_pkg::SLOT_DELTA)
                begin
                    dlen_next = vlen;
                end
                if (idx_reg == tepe_pkg::SLOT_DROPPED)
                begin
                    clen_next = vlen;
                end
                if (idx_reg == tepe_pkg::SLOT_DROPINC)
                begin
                    ilen_next = vlen;
                end
                idx_next = idx_reg + 3'd1;
            end
            tepe_pkg::S_CHECK:
            begin
                // Try the pending overflow packet and take its bytes off the space
                ok1_next = (space_reg > 16'(olen1));
                if (pend_snap_reg)
                begin
                    space_next = space_reg - 16'(olen1);
                end
            end
            tepe_pkg::S_DECIDE:
            begin
                idx_next      = '0;
                cur_ovf2_next = !pend_snap_reg;
                do_evt_next   = evt_ok;
                do_ovf2_next  = !evt_ok && ovf2_ok;
                priority if (skip_evt)
                begin
                    // Drop the event, keep the timestamp base
                    dropped_next = dinc_reg;
                    do_evt_next  = 1'b0;
                    do_ovf2_next = 1'b0;
                end
                else
                begin
                    last_ts_next = ts_reg;
                    pending_next = !evt_ok && !ovf2_ok;
                    if (evt_ok)
                    begin
                        dropped_next = pend_snap_reg ? 32'd0 : dropped_reg;
                    end
                    else if (ovf2_ok)
                    begin
                        dropped_next = 32'd0;
                    end
                    else
                    begin
                        dropped_next = pend_snap_reg ? 32'd2 : (dinc_reg + 32'd1);
                    end
                end
            end
            tepe_pkg::S_OVF_HDR:
            begin
                if (step)
                begin
                    ser_next = ovf_cnt_op;
                end
            end
            tepe_pkg::S_OVF_CNT:
            begin
                if (step)
                begin
                    ser_next = ser_done ? ovf_dlt_op : (ser_reg >> tepe_pkg::VARINT_SHIFT);
                end
            end
            tepe_pkg::S_OVF_DLT:
            begin
                if (step)
                begin
                    ser_next = ser_reg >> tepe_pkg::VARINT_SHIFT;
                    if (ser_done && !cur_ovf2_reg && !do_evt_reg && do_ovf2_reg)
                    begin
                        cur_ovf2_next = 1'b1;
                    end
                end
            end
            tepe_pkg::S_EVT_HDR:
            begin
                if (step)
                begin
                    idx_next = hdr_last ? '0 : (idx_reg + 3'd1);
                    if (hdr_last && (cnt_reg == '0))
                    begin
                        ser_next = delta_reg;
                    end
                end
            end
            tepe_pkg::S_EVT_LOAD:
            begin
                ser_next = val_rd;
            end
            tepe_pkg::S_EVT_VAL:
            begin
                if (step)
                begin
                    if (ser_done)
                    begin
                        idx_next = idx_reg + 3'd1;
                        ser_next = delta_reg;
                    end
                    else
                    begin
                        ser_next = ser_reg >> tepe_pkg::VARINT_SHIFT;
                    end
                end
            end
            tepe_pkg::S_EVT_DLT:
            begin
                if (step)
                begin
                    ser_next = ser_reg >> tepe_pkg::VARINT_SHIFT;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tepe_pkg::S_IDLE;
            tracing_on_reg <= 1'b0;
            class_mask_reg <= '0;
            ovf_id_reg     <= 5'd1;
            pending_reg    <= 1'b0;
            dropped_reg    <= '0;
            last_ts_reg    <= '0;
            idx_reg        <= '0;
            do_evt_reg     <= 1'b0;
            do_ovf2_reg    <= 1'b0;
            cur_ovf2_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pending_reg  <= pending_next;
            dropped_reg  <= dropped_next;
            last_ts_reg  <= last_ts_next;
            idx_reg      <= idx_next;
            do_evt_reg   <= do_evt_next;
            do_ovf2_reg  <= do_ovf2_next;
            cur_ovf2_reg <= cur_ovf2_next;
            // Take configuration writes
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    tepe_pkg::REG_TRACING_ON:  tracing_on_reg <= cfg_data[0];
                    tepe_pkg::REG_CLASS_MASK:  class_mask_reg <= cfg_data[7:0];
                    tepe_pkg::REG_OVERFLOW_ID: ovf_id_reg     <= cfg_data[4:0];
                    default:                   ovf_id_reg     <= ovf_id_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        id_reg        <= id_next;
        cnt_reg       <= cnt_next;
        ts_reg        <= ts_next;
        space_reg     <= space_next;
        delta_reg     <= delta_next;
        dcnt_reg      <= dcnt_next;
        dinc_reg      <= dinc_next;
        pend_snap_reg <= pend_snap_next;
        plen_reg      <= plen_next;
        dlen_reg      <= dlen_next;
        clen_reg      <= clen_next;
        ilen_reg      <= ilen_next;
        ok1_reg       <= ok1_next;
        ser_reg       <= ser_next;
        if (accept)
        begin
            val_reg[0] <= value_a;
            val_reg[1] <= value_b;
            val_reg[2] <= value_c;
            val_reg[3] <= value_d;
        end
    end

    // No input is taken while bytes are offered
    a_busy_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while a packet is being emitted");

    // Outside overflow mode nothing is counted as dropped
    a_dropped_only_in_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !pending_reg |-> (dropped_reg == 32'd0))
        else $error("dropped count nonzero in normal mode");

    // The drop counter moves only on the decision cycle
    a_dropped_at_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (dropped_reg != $past(dropped_reg)) |-> ($past(state_reg) == tepe_pkg::S_DECIDE))
        else $error("dropped count changed outside the decision cycle");

    // The final byte of an item ends the output burst
    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_byte) |=> !out_valid)
        else $error("output continues after the last byte");

endmodule

[design/tepe_vlen.sv]
module tepe_vlen
(
    input  logic [31:0]                  value,
    output logic [tepe_pkg::VLEN_W-1:0]  nbytes
);

    // Count the 7-bit groups up to the highest set one
    always_comb
    begin
        priority if (value[31:28] != '0)
        begin
            nbytes = 3'd5;
        end
        else if (value[27:21] != '0)
        begin
            nbytes = 3'd4;
        end
        else if (value[20:14] != '0)
        begin
            nbytes = 3'd3;
        end
        else if (value[13:7] != '0)
        begin
            nbytes = 3'd2;
        end
        else
        begin
            nbytes = 3'd1;
        end
    end

endmodule

[dv/tb_trace_event_packet_encoder_top.sv]
`timescale 1ns / 100ps

module tb_trace_event_packet_encoder_top;

    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [7:0]       id;
        logic [2:0]       cls;
        logic [2:0]       cnt;
        logic [3:0][31:0] vals;
        logic [31:0]      ts;
        logic [15:0]      space;
    } trace_event_t;

    typedef struct packed {
        logic [7:0] data;
        logic       ovf;
        logic       last;
    } packet_byte_t;

    // Packet under construction, byte 0 in the low bits
    typedef struct packed {
        logic [319:0] data;
        logic [5:0]   len;
    } byte_buf_t;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  event_id    = '0;
    logic [2:0]  event_class = '0;
    logic [2:0]  value_count = '0;
    logic [31:0] value_a     = '0;
    logic [31:0] value_b     = '0;
    logic [31:0] value_c     = '0;
    logic [31:0] value_d     = '0;
    logic [31:0] timestamp   = '0;
    logic [15:0] fifo_space  = '0;

    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [7:0]  out_byte;
    logic        is_overflow_packet;
    logic        last_byte;

    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [tepe_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]                      cfg_data  = '0;

    // Register mirror and encoder state
    logic        trace_en    = 1'b0;
    logic [7:0]  class_mask  = 8'h00;
    logic [4:0]  ovf_id      = 5'd1;
    logic        ovf_pending = 1'b0;
    logic [31:0] last_ts     = '0;
    logic [31:0] drop_cnt    = '0;

    trace_event_t pending_events[$];
    packet_byte_t expected_bytes[$];
    trace_event_t drive_evt;

    int unsigned queued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned error_count    = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned in_hold        = 0;
    int unsigned out_hold       = 0;
    bit          idle_en        = 1'b1;
    logic [31:0] ts_cursor      = '0;

    trace_event_packet_encoder_top i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .event_id           (event_id),
        .event_class        (event_class),
        .value_count        (value_count),
        .value_a            (value_a),
        .value_b            (value_b),
        .value_c            (value_c),
        .value_d            (value_d),
        .timestamp          (timestamp),
        .fifo_space         (fifo_space),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .out_byte           (out_byte),
        .is_overflow_packet (is_overflow_packet),
        .last_byte          (last_byte),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic byte_buf_t buf_push(input byte_buf_t b, input logic [7:0] x);
        b.data[b.len*8 +: 8] = x;
        b.len = b.len + 6'd1;
        return b;
    endfunction

    // 7 bits per byte, low group first, top bit flags more bytes
    function automatic byte_buf_t buf_push_varint(input byte_buf_t b, input logic [31:0] v);
        logic [31:0] x;
        x = v;
        while (x > 32'h7F)
        begin
            b = buf_push(b, {1'b1, x[6:0]});
            x = x >> 7;
        end
        return buf_push(b, {1'b0, x[6:0]});
    endfunction

    function automatic void queue_packet(input byte_buf_t b, input logic ovf);
        packet_byte_t pb;
        int i;
        for (i = 0; i < b.len; i++)
        begin
            pb.data = b.data[i*8 +: 8];
            pb.ovf  = ovf;
            pb.last = 1'b0;
            expected_bytes.push_back(pb);
        end
    endfunction

    // Try the overflow packet against the given room; return bytes used, 0 if it failed
    function automatic int unsigned send_overflow(input int unsigned room,
                                                  input logic [31:0] ts);
        byte_buf_t pkt;
        pkt = '0;
        pkt = buf_push(pkt, {3'b000, ovf_id});
        pkt = buf_push_varint(pkt, drop_cnt);
        pkt = buf_push_varint(pkt, ts - last_ts);
        if (room > pkt.len)
        begin
            queue_packet(pkt, 1'b1);
            ovf_pending = 1'b0;
            last_ts     = ts;
            drop_cnt    = '0;
            return pkt.len;
        end
        drop_cnt = drop_cnt + 32'd1;
        return 0;
    endfunction

    // Work out the bytes one accepted event produces and advance the state
    function automatic void encode_event(input trace_event_t e);
        byte_buf_t    pkt;
        byte_buf_t    payload;
        int unsigned  room;
        int unsigned  used;
        int           i;
        int           n;
        int           n_prior;
        logic [31:0]  base;
        packet_byte_t tail;

        if (!trace_en || class_mask[e.cls])
            return;

        n = (e.cnt > tepe_pkg::EFF_MAX_VALUES) ? tepe_pkg::EFF_MAX_VALUES : e.cnt;
        payload = '0;
        for (i = 0; i < n; i++)
            payload = buf_push_varint(payload, e.vals[i]);

        pkt = '0;
        if (e.id < tepe_pkg::SHORT_ID_LIMIT)
            pkt = buf_push(pkt, e.id);
        else
        begin
            if (e.id > tepe_pkg::LONG_ID_MAX)
            begin
                pkt = buf_push(pkt, e.id | tepe_pkg::CONT_BIT);
                pkt = buf_push(pkt, e.id >> tepe_pkg::VARINT_SHIFT);
            end
            else
                pkt = buf_push(pkt, e.id);
            // four values never reach 128 payload bytes, so the length is one byte
            pkt = buf_push(pkt, 8'(payload.len));
        end
        for (i = 0; i < payload.len; i++)
            pkt = buf_push(pkt, payload.data[i*8 +: 8]);
        base = last_ts;
        pkt  = buf_push_varint(pkt, e.ts - base);

        room    = e.space;
        n_prior = expected_bytes.size();
        if (ovf_pending)
        begin
            used = send_overflow(room, e.ts);
            if (ovf_pending)
                return;
            room = room - used;
        end

        if (room > pkt.len)
            queue_packet(pkt, 1'b0);
        else
        begin
            ovf_pending = 1'b1;
            drop_cnt    = drop_cnt + 32'd1;
            void'(send_overflow(room, e.ts));
        end
        last_ts = e.ts;

        // flag the final byte of this event
        if (expected_bytes.size() > n_prior)
        begin
            tail = expected_bytes.pop_back();
            tail.last = 1'b1;
            expected_bytes.push_back(tail);
        end
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    function automatic void queue_event(input logic [7:0] id, input logic [2:0] cls,
                                        input logic [2:0] cnt, input logic [3:0][31:0] vals,
                                        input logic [31:0] ts, input logic [15:0] space);
        trace_event_t e;
        e.id    = id;
        e.cls   = cls;
        e.cnt   = cnt;
        e.vals  = vals;
        e.ts    = ts;
        e.space = space;
        pending_events.push_back(e);
        queued_count++;
    endfunction

    // Spread values over every varint length
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 127);
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'd127;
                    1: return 32'd128;
                    2: return 32'd16383;
                    3: return 32'd16384;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [31:0] next_timestamp();
        case ($urandom_range(0, 9))
            0: ts_cursor = $urandom;
            1: ts_cursor = ts_cursor + $urandom_range(0, 1 << 20);
            default: ts_cursor = ts_cursor + $urandom_range(0, 300);
        endcase
        return ts_cursor;
    endfunction

    // Mostly roomy events; now and then a run of tight FIFO space to force overflow
    function automatic void queue_random_events(input int count);
        int               k;
        int               tight_left;
        logic [7:0]       id;
        logic [2:0]       cls;
        logic [2:0]       cnt;
        logic [3:0][31:0] vals;
        logic [15:0]      space;
        tight_left = 0;
        for (k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 2))
                0: id = 8'($urandom_range(0, tepe_pkg::SHORT_ID_LIMIT - 1));
                1: id = 8'($urandom_range(tepe_pkg::SHORT_ID_LIMIT, tepe_pkg::LONG_ID_MAX));
                default: id = 8'($urandom_range(tepe_pkg::LONG_ID_MAX + 1, 255));
            endcase
            cls = 3'($urandom_range(0, 7));
            if (class_mask != 8'hFF && $urandom_range(0, 4) != 0)
                while (class_mask[cls])
                    cls = 3'($urandom_range(0, 7));
            cnt = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4))
                                             : 3'($urandom_range(5, 7));
            vals[0] = pick_value();
            vals[1] = pick_value();
            vals[2] = pick_value();
            vals[3] = pick_value();
            if (tight_left > 0)
            begin
                tight_left--;
                space = 16'($urandom_range(0, 40));
            end
            else if ($urandom_range(0, 11) == 0)
            begin
                tight_left = $urandom_range(1, 5);
                space = 16'($urandom_range(0, 40));
            end
            else if ($urandom_range(0, 3) == 0)
                space = 16'($urandom_range(0, 65535));
            else
                space = 16'($urandom_range(41, 65535));
            queue_event(id, cls, cnt, vals, next_timestamp(), space);
        end
    endfunction

    task automatic send_reg(input logic [tepe_pkg::CFG_INDEX_W-1:0] idx,
                            input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            tepe_pkg::REG_TRACING_ON:  trace_en   = val[0];
            tepe_pkg::REG_CLASS_MASK:  class_mask = val[7:0];
            tepe_pkg::REG_OVERFLOW_ID: ovf_id     = val[4:0];
            default: ;
        endcase
    endtask

    task automatic write_regs(input logic en, input logic [7:0] mask, input logic [4:0] oid);
        send_reg(tepe_pkg::REG_TRACING_ON, {31'b0, en});
        send_reg(tepe_pkg::REG_CLASS_MASK, {24'b0, mask});
        send_reg(tepe_pkg::REG_OVERFLOW_ID, {27'b0, oid});
        cfg_valid <= 1'b0;
    endtask

    // Wait until every item is taken and every byte seen, then let dropped items finish
    task automatic wait_idle();
        while (accepted_count != queued_count || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Event driver: hold while stalled, advance on accept, insert idle bursts
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            encode_event(drive_evt);
            accepted_count++;
        end
        if (!in_valid || !in_stall)
        begin
            if (in_hold > 0)
            begin
                in_hold--;
                in_valid <= 1'b0;
            end
            else if (pending_events.size() > 0)
            begin
                drive_evt    = pending_events.pop_front();
                event_id    <= drive_evt.id;
                event_class <= drive_evt.cls;
                value_count <= drive_evt.cnt;
                value_a     <= drive_evt.vals[0];
                value_b     <= drive_evt.vals[1];
                value_c     <= drive_evt.vals[2];
                value_d     <= drive_evt.vals[3];
                timestamp   <= drive_evt.ts;
                fifo_space  <= drive_evt.space;
                in_valid    <= 1'b1;
                if (idle_en && $urandom_range(0, 9) == 0)
                    in_hold = $urandom_range(1, 15);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Byte monitor: compare against the oldest expected byte, stall in bursts
    always @(posedge clk)
    begin
        packet_byte_t exp_b;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
                flag_error($sformatf("unexpected byte %02h ovf %0b last %0b",
                                     out_byte, is_overflow_packet, last_byte));
            else
            begin
                exp_b = expected_bytes.pop_front();
                if (out_byte !== exp_b.data || is_overflow_packet !== exp_b.ovf ||
                    last_byte !== exp_b.last)
                    flag_error($sformatf({"byte mismatch: expected %02h ovf %0b last %0b, ",
                                          "got %02h ovf %0b last %0b"},
                                         exp_b.data, exp_b.ovf, exp_b.last,
                                         out_byte, is_overflow_packet, last_byte));
            end
        end
        if (out_hold > 0)
        begin
            out_hold--;
            out_stall <= 1'b1;
        end
        else if (idle_en && $urandom_range(0, 11) == 0)
        begin
            out_hold = $urandom_range(0, 14);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Abort when nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_trace_event_packet_encoder_top failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tracing is off after reset: these events leave no trace
        ts_cursor = 32'd50;
        queue_random_events(3);
        wait_idle();

        // directed: id forms, every class and count, value extremes, overflow ramp
        write_regs(1'b1, 8'h00, 5'd0);
        queue_event(8'd0,   3'd0, 3'd0, '0, 32'd1000, 16'hFFFF);
        queue_event(8'd23,  3'd1, 3'd1, '0, 32'd1010, 16'd1000);
        queue_event(8'd24,  3'd2, 3'd2, {32'd0, 32'd0, 32'd128, 32'd127}, 32'd1020, 16'd1000);
        queue_event(8'd127, 3'd3, 3'd3, {32'd0, 32'h3FFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF},
                    32'd1100, 16'd1000);
        queue_event(8'd128, 3'd4, 3'd4, {4{32'hFFFF_FFFF}}, 32'd20000, 16'd1000);
        queue_event(8'd255, 3'd5, 3'd5, {32'h1000_0000, 32'h20_0000, 32'h4000, 32'h80},
                    32'd20001, 16'd1000);
        queue_event(8'd200, 3'd6, 3'd7, {32'hDEAD_BEEF, 32'd1, 32'h8000_0000, 32'h5555_5555},
                    32'd5, 16'd1000);
        queue_event(8'd10,  3'd7, 3'd6, {32'hAAAA_AAAA, 32'd300, 32'd0, 32'h0FFF_FFFF},
                    32'hFFFF_FFFF, 16'd1000);
        queue_event(8'd3,   3'd0, 3'd0, '0, 32'd2, 16'd0);
        for (int s = 1; s <= 7; s++)
            queue_event(8'd3, 3'd0, 3'd0, '0, 32'd2 + s, 16'(s));
        queue_event(8'd255, 3'd1, 3'd4, {4{32'hFFFF_FFFF}}, 32'd100, 16'd20);
        queue_event(8'd255, 3'd1, 3'd4, {4{32'hFFFF_FFFF}}, 32'd200, 16'hFFFF);
        queue_event(8'd30,  3'd2, 3'd0, '0, 32'd300, 16'd3);
        queue_event(8'd30,  3'd2, 3'd0, '0, 32'd301, 16'hFFFF);
        wait_idle();

        write_regs(1'b1, 8'hA5, 5'd31);
        queue_random_events(125);
        wait_idle();

        // every class masked, then tracing off: all ignored
        write_regs(1'b1, 8'hFF, 5'd23);
        queue_random_events(5);
        wait_idle();
        write_regs(1'b0, 8'h00, 5'd23);
        queue_random_events(4);
        wait_idle();

        write_regs(1'b1, 8'h00, 5'd23);
        queue_random_events(120);
        wait_idle();

        // final stretch at full rate on both sides
        idle_en = 1'b0;
        write_regs(1'b1, 8'h5A, 5'd1);
        queue_random_events(120);
        wait_idle();

        if (error_count == 0)
            $display("tb_trace_event_packet_encoder_top passed");
        else
            $display("tb_trace_event_packet_encoder_top failed");
        $finish;
    end

endmodule

[files.f]
design/tepe_pkg.sv
design/tepe_vlen.sv
design/trace_event_packet_encoder_top.sv
dv/tb_trace_event_packet_encoder_top.sv
